[hw/rtl/dbs_pkg.sv]
// Shared types, constants and codes for the disk request batch scheduler.
`timescale 1ns / 1ps
`default_nettype none
package dbs_pkg;

  localparam int MAX_BATCH  = 16;
  localparam int BLOCK_BITS = 16;
  localparam int LEVEL_W    = 2;
  localparam int IDX_W      = $clog2(MAX_BATCH);
  localparam int CNT_W      = $clog2(MAX_BATCH + 1);
  localparam int LAT_W      = 17;
  localparam int ROT_W      = 10;
  localparam int TOTAL_W    = 32;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_ROTATION = 1'b1;

  // Service policy codes.
  localparam logic POLICY_FCFS = 1'b0;
  localparam logic POLICY_SSTF = 1'b1;

  typedef struct packed {
    logic [BLOCK_BITS-1:0] block;
    logic [LEVEL_W-1:0]    level;
    logic                  write;
  } entry_t;

  typedef struct packed {
    logic             policy;
    logic [ROT_W-1:0] rot_delay;
  } cfg_t;

  typedef struct packed {
    logic                  have;
    logic [BLOCK_BITS-1:0] distance;
    logic [LEVEL_W-1:0]    level;
  } best_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ISSUE
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/dbs_apb_regs.sv]
// APB configuration registers: service policy and rotational delay.
`timescale 1ns / 1ps
`default_nettype none
module dbs_apb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dbs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dbs_pkg::PDATA_W-1:0] pwdata,
  output logic      [dbs_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output dbs_pkg::cfg_t                    cfg
);
  import dbs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_POLICY:   cfg.policy    <= pwdata[0];
        REG_ROTATION: cfg.rot_delay <= pwdata[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POLICY:   prdata = PDATA_W'(cfg.policy);
      REG_ROTATION: prdata = PDATA_W'(cfg.rot_delay);
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/dbs_store.sv]
// Request store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dbs_store (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [dbs_pkg::IDX_W-1:0] wr_addr,
  input  wire dbs_pkg::entry_t           wr_data,
  input  wire logic                      rd_en,
  input  wire logic [dbs_pkg::IDX_W-1:0] rd_addr,
  output dbs_pkg::entry_t                rd_data
);
  import dbs_pkg::*;

  entry_t mem [MAX_BATCH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/dbs_seek_unit.sv]
// Shared seek unit: distance from the head and the better-candidate test.
`timescale 1ns / 1ps
`default_nettype none
module dbs_seek_unit (
  input  wire logic                           policy,
  input  wire logic [dbs_pkg::BLOCK_BITS-1:0] head,
  input  wire dbs_pkg::entry_t                cand,
  input  wire dbs_pkg::best_t                 best,
  output logic      [dbs_pkg::BLOCK_BITS-1:0] distance,
  output logic                                take
);
  import dbs_pkg::*;

  always_comb begin
    if (head >= cand.block) begin
      distance = head - cand.block;
    end else begin
      distance = cand.block - head;
    end
  end

  // First come first served takes the first pending entry; shortest seek
  // first prefers the smaller distance, then the lower level, and keeps the
  // earlier entry on a full tie.
  always_comb begin
    if (policy == POLICY_FCFS) begin
      take = !best.have;
    end else begin
      take = !best.have || (distance < best.distance) ||
             ((distance == best.distance) && (cand.level < best.level));
    end
  end

endmodule
`default_nettype wire

[hw/rtl/disk_request_batch_scheduler_core.sv]
// Top level of the disk request batch scheduler: sequencer, totals and ports.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Requests come in on the command channel: a beat is taken at a rising edge
//   where start is high and busy is low. A request that does not close the
//   batch is stored and busy stays low. A request with batch_end
//   set, or the one that fills the sixteen-entry store, closes the batch and
//   raises busy while the stored requests are issued in service order.
//   Each issued request appears on the result ports for one cycle, marked by
//   out_valid; the receiver cannot stall, so it must take every beat.
//   For each result the stored requests are scanned through the single read
//   port one entry a cycle, a drain state empties the read register, and an
//   issue state issues the pick and updates the head and totals. The last
//   result appears in the cycle where busy has already fallen again.
//   The policy and rotational delay registers sit on the APB port at byte
//   addresses 0 and 4. The user must write them only while the block is
//   idle; the block itself does not enforce this.
//   Reset clears the head position, the totals, the fill count and the
//   registers; the stored requests themselves are not cleared.
module disk_request_batch_scheduler_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // APB configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dbs_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [dbs_pkg::PDATA_W-1:0]    pwdata,
  output logic      [dbs_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready,
  // Command channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [dbs_pkg::BLOCK_BITS-1:0] block_number,
  input  wire logic [dbs_pkg::LEVEL_W-1:0]    priority_level,
  input  wire logic                           is_write,
  input  wire logic                           batch_end,
  // Result channel
  output logic                                out_valid,
  output logic      [dbs_pkg::BLOCK_BITS-1:0] served_block,
  output logic                                served_write,
  output logic      [dbs_pkg::LAT_W-1:0]      request_latency,
  output logic                                last_of_run,
  output logic      [dbs_pkg::TOTAL_W-1:0]    reads_total,
  output logic      [dbs_pkg::TOTAL_W-1:0]    writes_total,
  output logic      [dbs_pkg::TOTAL_W-1:0]    latency_total
);
  import dbs_pkg::*;

  cfg_t   cfg;
  state_t state, state_next;

  logic                  accept;
  logic                  closes;
  logic [CNT_W-1:0]      pending_count;
  logic [CNT_W-1:0]      batch_size;
  logic [CNT_W-1:0]      issued;
  logic [IDX_W-1:0]      scan_idx;
  logic                  scan_last;
  logic                  issue_last;
  logic [MAX_BATCH-1:0]  done_bits;

  logic                  pipe_vld;
  logic [IDX_W-1:0]      pipe_idx;
  entry_t                wr_entry;
  entry_t                rd_entry;

  best_t                 best;
  logic [IDX_W-1:0]      best_idx;
  logic [BLOCK_BITS-1:0] best_block;
  logic                  best_write;
  logic [BLOCK_BITS-1:0] cand_dist;
  logic                  cand_take;

  logic [BLOCK_BITS-1:0] head_position;
  logic [TOTAL_W-1:0]    read_counter;
  logic [TOTAL_W-1:0]    write_counter;
  logic [TOTAL_W-1:0]    latency_counter;
  logic [LAT_W-1:0]      pick_latency;

  dbs_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign wr_entry = '{block: block_number, level: priority_level, write: is_write};

  dbs_store u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (pending_count[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (state == ST_SCAN),
    .rd_addr (scan_idx),
    .rd_data (rd_entry)
  );

  dbs_seek_unit u_seek (
    .policy   (cfg.policy),
    .head     (head_position),
    .cand     (rd_entry),
    .best     (best),
    .distance (cand_dist),
    .take     (cand_take)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  // The batch closes on batch_end or when this request fills the store.
  assign closes = batch_end || (pending_count == CNT_W'(MAX_BATCH - 1));

  assign scan_last  = (scan_idx == IDX_W'(batch_size - CNT_W'(1)));
  assign issue_last = ((issued + CNT_W'(1)) == batch_size);

  assign pick_latency = LAT_W'(best.distance) + LAT_W'(cfg.rot_delay);

  // Sequencer: state register and next-state logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && closes) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        state_next = issue_last ? ST_IDLE : ST_SCAN;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Batch bookkeeping: fill count, batch size, issue count and done bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= '0;
      batch_size    <= '0;
      issued        <= '0;
      done_bits     <= '0;
    end else begin
      if (accept) begin
        if (closes) begin
          pending_count <= '0;
          batch_size    <= pending_count + CNT_W'(1);
          issued        <= '0;
          done_bits     <= '0;
        end else begin
          pending_count <= pending_count + CNT_W'(1);
        end
      end
      if (state == ST_ISSUE) begin
        issued              <= issued + CNT_W'(1);
        done_bits[best_idx] <= 1'b1;
      end
    end
  end

  // Scan address and read pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      pipe_vld <= 1'b0;
    end else begin
      pipe_vld <= (state == ST_SCAN);
      if (state == ST_SCAN && !scan_last) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end else if (state != ST_SCAN) begin
        scan_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      pipe_idx <= scan_idx;
    end
  end

  // Best candidate of the current scan. Entries already issued are skipped.
  always_ff @(posedge clk) begin
    if (rst) begin
      best.have <= 1'b0;
    end else if (state == ST_ISSUE || state == ST_IDLE) begin
      best.have <= 1'b0;
    end else if (pipe_vld && !done_bits[pipe_idx] && cand_take) begin
      best.have <= 1'b1;
    end
    if (pipe_vld && !done_bits[pipe_idx] && cand_take) begin
      best.distance <= cand_dist;
      best.level    <= rd_entry.level;
      best_idx      <= pipe_idx;
      best_block    <= rd_entry.block;
      best_write    <= rd_entry.write;
    end
  end

  // Head position and running totals move once per issued request.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_position   <= '0;
      read_counter    <= '0;
      write_counter   <= '0;
      latency_counter <= '0;
    end else if (state == ST_ISSUE) begin
      head_position   <= best_block;
      latency_counter <= latency_counter + TOTAL_W'(pick_latency);
      if (best_write) begin
        write_counter <= write_counter + TOTAL_W'(1);
      end else begin
        read_counter <= read_counter + TOTAL_W'(1);
      end
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == ST_ISSUE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ISSUE) begin
      served_block    <= best_block;
      served_write    <= best_write;
      request_latency <= pick_latency;
      last_of_run     <= issue_last;
    end
  end

  assign reads_total   = read_counter;
  assign writes_total  = write_counter;
  assign latency_total = latency_counter;

  // The final beat of a batch finds the block idle again.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> !busy)
    else $error("block still busy on the final result beat");

  // Any other result beat is followed by more work on the same batch.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> busy)
    else $error("block went idle before the batch was issued");

  // Every issue step produces exactly one result beat, never two in a row.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_ISSUE |=> out_valid ##1 !out_valid)
    else $error("issue step did not produce a single result beat");

  // An issue step always has a candidate to issue.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_ISSUE |-> best.have)
    else $error("issue step without a selected request");

  // The fill count never reaches the store depth while collecting.
  assert property (@(posedge clk) disable iff (rst)
    pending_count < CNT_W'(MAX_BATCH))
    else $error("fill count overran the store");

endmodule
`default_nettype wire
